>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by percentile_rank_lookup_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define PRL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PRL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Field widths, codes and constants of the percentile rank lookup unit.
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam int OPCODE_W   = 1;
  localparam int IDX_W      = 8;
  localparam int VAL_W      = 17;
  localparam int SCORE_W    = 32;
  localparam int INC_W      = 24;
  localparam int TOP_W      = 8;
  localparam int PR_W       = 23;
  localparam int REGION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int POS_FRAC   = 16;

  localparam logic [PR_W-1:0] PR_FULL = 23'd6553600;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [REGION_W-1:0] {
    REGION_BELOW = 2'd0,
    REGION_MID   = 2'd1,
    REGION_ABOVE = 2'd2
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SCORE = 2'd0,
    CFG_INCREMENT = 2'd1,
    CFG_TOP_LOC   = 2'd2
  } cfg_idx_t;

endpackage

>>> rtl/prl_item_if.sv
// ----------------------------------------------------------------------------
// prl_item_if
// Input channel: table writes and rank queries.
// ----------------------------------------------------------------------------
interface prl_item_if import prl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [IDX_W-1:0]          entry_index;
  logic [VAL_W-1:0]          entry_value;
  logic signed [SCORE_W-1:0] query_score;

  modport source (output valid, opcode, entry_index, entry_value, query_score, input ready);
  modport sink   (input valid, opcode, entry_index, entry_value, query_score, output ready);
endinterface

>>> rtl/prl_result_if.sv
// ----------------------------------------------------------------------------
// prl_result_if
// Output channel: percentile rank and region.
// ----------------------------------------------------------------------------
interface prl_result_if import prl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PR_W-1:0]     percent_rank;
  logic [REGION_W-1:0] region;

  modport source (output valid, percent_rank, region, input ready);
  modport sink   (input valid, percent_rank, region, output ready);
endinterface

>>> rtl/prl_cfg_if.sv
// ----------------------------------------------------------------------------
// prl_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface prl_cfg_if import prl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/percentile_rank_lookup_unit.sv
// ----------------------------------------------------------------------------
// percentile_rank_lookup_unit: a write beat stores an in-range table entry; a
// query runs PREP, CHECK, the restoring divider, two table reads, MUL, SUM,
// SCALE and FIN, or CHECK to FIN when below or above range; no new beat until IDLE.
// Reset clears control and configuration; the table is undefined until written.
// ----------------------------------------------------------------------------
module percentile_rank_lookup_unit import prl_pkg::*; #(
  parameter int TABLE_DEPTH   = 256,
  parameter int CDF_FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  prl_cfg_if.sink      cfg,
  prl_item_if.sink     item,
  prl_result_if.source result
);

`include "assert_macros.svh"

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW  = CDF_FRAC_BITS + 1;
  localparam int XW  = (EW > VAL_W) ? EW : VAL_W;
  localparam int IW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int TW  = (AW > TOP_W) ? AW : TOP_W;
  localparam int QW  = INC_W + 1;
  localparam int DW  = SCORE_W + 3;
  localparam int BW  = AW + 1 + QW;
  localparam int CW  = (BW + 1 > DW + 1) ? BW + 1 : DW + 1;
  localparam int QB  = AW + POS_FRAC;
  localparam int NW  = $clog2(QB + 1);
  localparam int PW  = EW + 18;
  localparam int SW  = PW + 8;
  localparam int RW  = SW - CDF_FRAC_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_RDLO  = 10'b0000010000,
    S_RDHI  = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_SUM   = 10'b0010000000,
    S_SCALE = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state;

  // configuration
  logic signed [SCORE_W-1:0] min_score;
  logic [INC_W-1:0]          score_increment;
  logic [TOP_W-1:0]          top_location;

  // table
  logic [EW-1:0] cdf_mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  // query datapath
  logic signed [DW-1:0]  d;
  logic [QW-1:0]         q;
  logic [AW-1:0]         top_k;
  logic [BW-1:0]         bound;
  logic [QW-1:0]         rem;
  logic [QB-1:0]         quo;
  logic [NW-1:0]         cnt;
  logic [EW-1:0]         lo;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  acc;
  logic signed [SW-1:0]  sacc;
  region_t               region;

  logic                  res_valid;
  logic [PR_W-1:0]       res_pr;
  region_t               res_region;

  // combinational helpers
  logic                      item_fire;
  logic [XW-1:0]             val_ext;
  logic [IW-1:0]             idx_ext;
  logic [INC_W-1:0]          inc_eff;
  logic signed [SCORE_W:0]   diff;
  logic signed [DW-1:0]      d_next;
  logic [TW-1:0]             top_ext;
  logic [TW-1:0]             top_sat;
  logic [CW-1:0]             d_u;
  logic [CW-1:0]             bound_u;
  logic [CW-1:0]             d_shr;
  logic [QW+1:0]             trial;
  logic [AW-1:0]             k;
  logic [EW:0]               hi_lo_diff;
  logic [RW-1:0]             sacc_shr;
  logic [PR_W-1:0]           pr_sat;
  logic                      out_free;

  assign item_fire = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;
  assign out_free   = !res_valid || result.ready;

  assign val_ext  = XW'(item.entry_value);
  assign idx_ext  = IW'(item.entry_index);
  assign inc_eff  = (score_increment == '0) ? INC_W'(1) : score_increment;
  assign diff     = {item.query_score[SCORE_W-1], item.query_score}
                  - {min_score[SCORE_W-1], min_score};
  assign d_next   = {diff[SCORE_W], diff, 1'b0} + $signed(DW'(inc_eff));
  assign top_ext  = TW'(top_location);
  assign top_sat  = (top_ext > TW'(TABLE_DEPTH - 1)) ? TW'(TABLE_DEPTH - 1) : top_ext;
  assign d_u      = CW'(d[DW-2:0]);
  assign bound_u  = CW'(bound);
  assign d_shr    = d_u >> AW;
  assign trial    = {1'b0, rem, quo[QB-1]} - {2'b00, q};
  assign k        = quo[QB-1:POS_FRAC];
  assign rd_addr  = (state == S_RDLO) ? (k - AW'(1)) : k;
  assign hi_lo_diff = {1'b0, rd_data} - {1'b0, lo};
  assign sacc_shr = sacc[SW-1:CDF_FRAC_BITS];
  assign pr_sat   = (sacc <= 0) ? '0 :
                    (sacc_shr > RW'(PR_FULL)) ? PR_FULL : sacc_shr[PR_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_score       <= '0;
      score_increment <= INC_W'(256);
      top_location    <= TOP_W'(255);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MIN_SCORE: min_score       <= $signed(cfg.data[SCORE_W-1:0]);
        CFG_INCREMENT: score_increment <= cfg.data[INC_W-1:0];
        CFG_TOP_LOC:   top_location    <= cfg.data[TOP_W-1:0];
        default: ;
      endcase
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (item_fire && opcode_t'(item.opcode) == OP_WRITE &&
        {1'b0, idx_ext} < (IW + 1)'(TABLE_DEPTH)) begin
      cdf_mem[idx_ext[AW-1:0]] <= val_ext[EW-1:0];
    end
    rd_data <= cdf_mem[rd_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_fire && opcode_t'(item.opcode) == OP_QUERY) begin
            state <= S_PREP;
          end
        end
        S_PREP:  state <= S_CHECK;
        S_CHECK: begin
          if (d < 0 || d_u >= bound_u) begin
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == NW'(1)) begin
            state <= S_RDLO;
          end
        end
        S_RDLO:  state <= S_RDHI;
        S_RDHI:  state <= S_MUL;
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_SCALE;
        S_SCALE: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        d     <= d_next;
        q     <= {inc_eff, 1'b0};
        top_k <= top_sat[AW-1:0];
      end
      S_PREP: begin
        bound <= BW'((AW + 1)'(top_k) + (AW + 1)'(1)) * BW'(q);
      end
      S_CHECK: begin
        rem <= d_shr[QW-1:0];
        quo <= {d_u[AW-1:0], {POS_FRAC{1'b0}}};
        cnt <= NW'(QB);
        if (d < 0) begin
          region <= REGION_BELOW;
        end else if (d_u >= bound_u) begin
          region <= REGION_ABOVE;
        end else begin
          region <= REGION_MID;
        end
      end
      S_DIV: begin
        cnt <= cnt - NW'(1);
        if (!trial[QW+1]) begin
          rem <= trial[QW-1:0];
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          rem <= {rem[QW-2:0], quo[QB-1]};
          quo <= {quo[QB-2:0], 1'b0};
        end
      end
      S_RDHI: begin
        lo <= (k == '0) ? '0 : rd_data;
      end
      S_MUL: begin
        prod <= PW'($signed({1'b0, quo[POS_FRAC-1:0]}) * $signed(hi_lo_diff));
      end
      S_SUM: begin
        acc <= $signed(PW'({lo, {POS_FRAC{1'b0}}})) + prod;
      end
      S_SCALE: begin
        sacc <= SW'(acc) * $signed(SW'(100));
      end
      S_FIN: begin
        if (out_free) begin
          res_region <= region;
          case (region)
            REGION_MID:   res_pr <= pr_sat;
            REGION_ABOVE: res_pr <= PR_FULL;
            default:      res_pr <= '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign result.valid        = res_valid;
  assign result.percent_rank = res_pr;
  assign result.region       = res_region;

  `PRL_ASSERT(a_query_leaves_idle, item.valid && item.ready && item.opcode == OP_QUERY |=> state != S_IDLE, "query beat did not start work")
  `PRL_ASSERT(a_region_above_full, result.valid && result.region == REGION_ABOVE |-> result.percent_rank == PR_FULL, "above range without full rank")
  `PRL_ASSERT(a_region_below_zero, result.valid && result.region == REGION_BELOW |-> result.percent_rank == '0, "below range with nonzero rank")
  `PRL_ASSERT_ALWAYS(a_rank_bounded, result.valid |-> result.percent_rank <= PR_FULL, "rank above full scale")

endmodule
